// File: rtl/assert_macros.svh
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LSI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LSI_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSI_ASSERT(label, prop, msg)
`define LSI_ASSERT_RST(label, prop, msg)
`endif
`endif

// File: rtl/lsi_pkg.sv
// types, widths and helpers for the segment intersection pipeline
package lsi_pkg;
	localparam int CW = 32;                 // coordinate bits used
	localparam int TF = 24;                 // fraction bits of t
	localparam int DW = CW + 1;             // coordinate difference
	localparam int PW = 2 * DW;             // product of two differences
	localparam int WW = PW + 1;             // cross-product sum
	localparam int LW = TF + 1 + DW;        // lerp product
	localparam int SW = DW + 1;             // lerp sum
	localparam int FRONT_STAGES = 5;
	localparam int LATENCY = FRONT_STAGES + TF + 1 + 2;
	localparam int ADDR_W = 3;
	localparam logic [0:0] REG_THRESHOLD = 1'b0;
	localparam logic [31:0] THRESHOLD_RESET = 32'd42949673;

	typedef struct packed {
		logic signed [31:0] seg_a_start_x;
		logic signed [31:0] seg_a_start_y;
		logic signed [31:0] seg_a_end_x;
		logic signed [31:0] seg_a_end_y;
		logic signed [31:0] seg_b_start_x;
		logic signed [31:0] seg_b_start_y;
		logic signed [31:0] seg_b_end_x;
		logic signed [31:0] seg_b_end_y;
	} lsi_in_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] cross_x;
		logic signed [31:0] cross_y;
	} lsi_out_t;

	typedef struct packed {
		logic                 direct;   // result known without the divide
		logic                 hit;
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
	} lsi_side_t;

	typedef struct packed {
		logic            valid;
		logic [WW-1:0]   rem;
		logic [WW-1:0]   den;
		logic [TF:0]     q;
		lsi_side_t       side;
	} lsi_div_t;

	function automatic logic signed [DW-1:0] coord(input logic [31:0] v);
		logic signed [CW-1:0] c;
		c = signed'(v[CW-1:0]);
		return DW'(c);
	endfunction
endpackage

// File: rtl/lsi_front.sv
// differences, cross products, endpoint and range checks
module lsi_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  lsi_pkg::lsi_in_t seg,
	input  logic [31:0]     threshold,
	output lsi_pkg::lsi_div_t div_o
);
	localparam int CW = lsi_pkg::CW;
	localparam int DW = lsi_pkg::DW;
	localparam int PW = lsi_pkg::PW;
	localparam int WW = lsi_pkg::WW;

	logic             v_s1;
	lsi_pkg::lsi_in_t seg_s1;

	logic signed [DW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
	logic v_s2, m1_s2, m2_s2;
	logic signed [DW-1:0] x1_s2, y1_s2, x2_s2, y2_s2;
	logic signed [DW-1:0] d12x_s2, d12y_s2, d34x_s2, d34y_s2, d13x_s2, d13y_s2;

	logic v_s3, m1_s3, m2_s3;
	logic signed [DW-1:0] x1_s3, y1_s3, x2_s3, y2_s3, dx_s3, dy_s3;
	logic signed [PW-1:0] pd1_s3, pd2_s3, pt1_s3, pt2_s3, pu1_s3, pu2_s3;

	logic v_s4, m1_s4, m2_s4;
	logic signed [DW-1:0] x1_s4, y1_s4, x2_s4, y2_s4, dx_s4, dy_s4;
	logic signed [WW-1:0] den_s4, tn_s4, un_s4;

	logic [WW-1:0] ad, at, au;
	logic ok, t_ok, u_ok;
	lsi_pkg::lsi_div_t nxt;

	always_comb begin
		x1 = lsi_pkg::coord(seg_s1.seg_a_start_x);
		y1 = lsi_pkg::coord(seg_s1.seg_a_start_y);
		x2 = lsi_pkg::coord(seg_s1.seg_a_end_x);
		y2 = lsi_pkg::coord(seg_s1.seg_a_end_y);
		x3 = lsi_pkg::coord(seg_s1.seg_b_start_x);
		y3 = lsi_pkg::coord(seg_s1.seg_b_start_y);
		x4 = lsi_pkg::coord(seg_s1.seg_b_end_x);
		y4 = lsi_pkg::coord(seg_s1.seg_b_end_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		seg_s1 <= seg;
		// stage 2: differences and endpoint matches
		m1_s2 <= (x1 == x3 && y1 == y3) || (x1 == x4 && y1 == y4);
		m2_s2 <= (x2 == x3 && y2 == y3) || (x2 == x4 && y2 == y4);
		x1_s2 <= x1;
		y1_s2 <= y1;
		x2_s2 <= x2;
		y2_s2 <= y2;
		d12x_s2 <= x1 - x2;
		d12y_s2 <= y1 - y2;
		d34x_s2 <= x3 - x4;
		d34y_s2 <= y3 - y4;
		d13x_s2 <= x1 - x3;
		d13y_s2 <= y1 - y3;
		// stage 3: six products
		pd1_s3 <= d12x_s2 * d34y_s2;
		pd2_s3 <= d12y_s2 * d34x_s2;
		pt1_s3 <= d13x_s2 * d34y_s2;
		pt2_s3 <= d13y_s2 * d34x_s2;
		pu1_s3 <= d12y_s2 * d13x_s2;
		pu2_s3 <= d12x_s2 * d13y_s2;
		m1_s3 <= m1_s2;
		m2_s3 <= m2_s2;
		x1_s3 <= x1_s2;
		y1_s3 <= y1_s2;
		x2_s3 <= x2_s2;
		y2_s3 <= y2_s2;
		dx_s3 <= -d12x_s2;
		dy_s3 <= -d12y_s2;
		// stage 4: denominator and numerators
		den_s4 <= WW'(pd1_s3) - WW'(pd2_s3);
		tn_s4 <= WW'(pt1_s3) - WW'(pt2_s3);
		un_s4 <= WW'(pu1_s3) - WW'(pu2_s3);
		m1_s4 <= m1_s3;
		m2_s4 <= m2_s3;
		x1_s4 <= x1_s3;
		y1_s4 <= y1_s3;
		x2_s4 <= x2_s3;
		y2_s4 <= y2_s3;
		dx_s4 <= dx_s3;
		dy_s4 <= dy_s3;
	end

	// stage 5: magnitudes, parallel test, t and u in the unit interval
	always_comb begin
		ad = den_s4[WW-1] ? WW'(-den_s4) : WW'(den_s4);
		at = tn_s4[WW-1] ? WW'(-tn_s4) : WW'(tn_s4);
		au = un_s4[WW-1] ? WW'(-un_s4) : WW'(un_s4);
		t_ok = (tn_s4 == '0 || tn_s4[WW-1] == den_s4[WW-1]) && ad >= at;
		u_ok = (un_s4 == '0 || un_s4[WW-1] == den_s4[WW-1]) && ad >= au;
		ok = den_s4 != '0 && ad >= WW'(threshold) && t_ok && u_ok;
		nxt.valid = v_s4;
		nxt.rem = at;
		nxt.den = ad;
		nxt.q = '0;
		nxt.side.direct = m1_s4 || m2_s4 || !ok;
		nxt.side.hit = m1_s4 || m2_s4;
		if (m1_s4) begin
			nxt.side.px = x1_s4[CW-1:0];
			nxt.side.py = y1_s4[CW-1:0];
		end else if (m2_s4) begin
			nxt.side.px = x2_s4[CW-1:0];
			nxt.side.py = y2_s4[CW-1:0];
		end else if (ok) begin
			nxt.side.px = x1_s4[CW-1:0];
			nxt.side.py = y1_s4[CW-1:0];
		end else begin
			nxt.side.px = '0;
			nxt.side.py = '0;
		end
		nxt.side.dx = dx_s4;
		nxt.side.dy = dy_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_o.valid <= 1'b0;
		end else begin
			div_o <= nxt;
		end
	end
endmodule

// File: rtl/lsi_div.sv
// pipelined restoring divider, one quotient bit per stage
module lsi_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lsi_pkg::lsi_div_t din,
	output lsi_pkg::lsi_div_t dout
);
	localparam int TF = lsi_pkg::TF;
	localparam int WW = lsi_pkg::WW;

	lsi_pkg::lsi_div_t st [TF+1];

	for (genvar k = 0; k <= TF; k++) begin : g_stage
		lsi_pkg::lsi_div_t prev, nxt;
		logic [WW-1:0] r_in;
		logic ge;

		always_comb begin
			prev = (k == 0) ? din : st[(k == 0) ? 0 : k-1];
			r_in = (k == 0) ? prev.rem : {prev.rem[WW-2:0], 1'b0};
			ge = r_in >= prev.den;
			nxt = prev;
			nxt.rem = ge ? r_in - prev.den : r_in;
			nxt.q = {prev.q[TF-1:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st[k].valid <= 1'b0;
			end else begin
				st[k] <= nxt;
			end
		end
	end

	assign dout = st[TF];
endmodule

// File: rtl/lsi_lerp.sv
// point on segment a from the quotient, floored products
module lsi_lerp (
	input  logic              clk,
	input  logic              arst_n,
	input  lsi_pkg::lsi_div_t din,
	output logic              done,
	output lsi_pkg::lsi_out_t result
);
	localparam int CW = lsi_pkg::CW;
	localparam int DW = lsi_pkg::DW;
	localparam int TF = lsi_pkg::TF;
	localparam int LW = lsi_pkg::LW;
	localparam int SW = lsi_pkg::SW;
	localparam logic [LW-1:0] RND = LW'((64'd1 << TF) - 64'd1);

	logic [DW-1:0] mx, my;
	logic v_s1, direct_s1, hit_s1, negx_s1, negy_s1;
	logic signed [CW-1:0] px_s1, py_s1;
	logic [LW-1:0] prx_s1, pry_s1;
	logic [SW-1:0] sx, sy;
	logic signed [SW-1:0] rx, ry;
	lsi_pkg::lsi_out_t nxt;

	assign mx = din.side.dx[DW-1] ? DW'(-din.side.dx) : DW'(din.side.dx);
	assign my = din.side.dy[DW-1] ? DW'(-din.side.dy) : DW'(din.side.dy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= din.valid;
			done <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		direct_s1 <= din.side.direct;
		hit_s1 <= din.side.hit;
		px_s1 <= din.side.px;
		py_s1 <= din.side.py;
		negx_s1 <= din.side.dx[DW-1];
		negy_s1 <= din.side.dy[DW-1];
		prx_s1 <= LW'(din.q) * LW'(mx);
		pry_s1 <= LW'(din.q) * LW'(my);
		result <= nxt;
	end

	always_comb begin
		sx = negx_s1 ? SW'((prx_s1 + RND) >> TF) : SW'(prx_s1 >> TF);
		sy = negy_s1 ? SW'((pry_s1 + RND) >> TF) : SW'(pry_s1 >> TF);
		rx = negx_s1 ? SW'(px_s1) - signed'(sx) : SW'(px_s1) + signed'(sx);
		ry = negy_s1 ? SW'(py_s1) - signed'(sy) : SW'(py_s1) + signed'(sy);
		if (direct_s1) begin
			nxt.hit = hit_s1;
			nxt.cross_x = 32'(px_s1);
			nxt.cross_y = 32'(py_s1);
		end else begin
			nxt.hit = 1'b1;
			nxt.cross_x = 32'(signed'(rx[CW-1:0]));
			nxt.cross_y = 32'(signed'(ry[CW-1:0]));
		end
	end
endmodule

// File: rtl/line_segment_intersection.sv
// line segment intersection: fully pipelined, one word per cycle
// throughput: one word every cycle, busy stays low; set by the one-bit-per-stage divider
// the receiver cannot stall, so results leave on a single-cycle done strobe
// reset: arst_n clears all valid bits and loads the parallel threshold reset value
`include "assert_macros.svh"
module line_segment_intersection (
	input  logic                          clk,
	input  logic                          arst_n,
	// word in
	input  logic                          start,
	output logic                          busy,
	input  lsi_pkg::lsi_in_t              seg,
	// word out
	output logic                          done,
	output lsi_pkg::lsi_out_t             result,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lsi_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	logic [31:0] thr_q;
	logic        wr_en;
	lsi_pkg::lsi_div_t front_out, div_out;

	// no stall anywhere: every start is taken
	assign busy = 1'b0;
	assign pready = 1'b1;

	// register write on the access cycle, index from the upper address bit
	assign wr_en = psel && penable && pwrite && paddr[2] == lsi_pkg::REG_THRESHOLD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= lsi_pkg::THRESHOLD_RESET;
		end else if (wr_en) begin
			thr_q <= pwdata;
		end
	end

	// reads outside the list return zero
	assign prdata = (paddr[2] == lsi_pkg::REG_THRESHOLD) ? thr_q : 32'd0;

	// differences, products, sums and checks
	lsi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.seg       (seg),
		.threshold (thr_q),
		.div_o     (front_out)
	);

	// t = |T| / |D| with TF fraction bits
	lsi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (front_out),
		.dout   (div_out)
	);

	// start + t * delta, also the output register
	lsi_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (div_out),
		.done   (done),
		.result (result)
	);

	// fixed latency from accept to strobe
	`LSI_ASSERT(a_latency, (start && !busy) |-> ##(lsi_pkg::LATENCY) done, "result strobe missing")
	// no-hit results carry a zero point
	`LSI_ASSERT(a_miss_zero, (done && !result.hit) |-> (result.cross_x == 32'd0 && result.cross_y == 32'd0), "miss with nonzero point")
	// a completed write shows up on the read data
	`LSI_ASSERT(a_cfg_write, $past(wr_en) |-> (thr_q == $past(pwdata)), "threshold write lost")
endmodule
